/* design/amb_pkg.sv */
// Shared constants, codes and controller/datapath bundles for the graph search block.
package amb_pkg;

  localparam int MaxVertices = 64;
  localparam int StackDepth  = 8192;
  localparam int VtxW        = $clog2(MaxVertices);
  localparam int CntW        = VtxW + 1;
  localparam int StkAw       = $clog2(StackDepth);
  localparam int SpW         = StkAw + 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_BFS = 2'd1,
    OP_DFS = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EDGE_RANGE  = 2'd1,
    ST_START_RANGE = 2'd2
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic          latch;
    logic          adj_rd_a;
    logic          adj_rd_b;
    logic          adj_wr_a;
    logic          adj_wr_b;
    logic          init;
    logic          pop;
    logic          fetch;
    logic          load_row;
    logic          scan;
    logic          finish;
    logic          reply;
    logic [1:0]    reply_status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       a_ok;
    logic       b_ok;
    logic       out_busy;
    logic       scan_end;
    logic       empty;
  } stat_t;

endpackage

/* design/amb_if.sv */
// Request and result channel interfaces for the graph search block.
interface amb_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [amb_pkg::VtxW-1:0]  vertex_a;
  logic [amb_pkg::VtxW-1:0]  vertex_b;

  modport source (output valid, operation, vertex_a, vertex_b, input ready);
  modport sink   (input valid, operation, vertex_a, vertex_b, output ready);
endinterface

interface amb_res_if;
  logic                      valid;
  logic                      ready;
  logic [amb_pkg::VtxW-1:0]  visited_vertex;
  logic [1:0]                status;
  logic                      last;

  modport source (output valid, visited_vertex, status, last, input ready);
  modport sink   (input valid, visited_vertex, status, last, output ready);
endinterface

/* design/amb_datapath.sv */
// Datapath: adjacency memory, queue and stack memories, visit marks and result register.
module amb_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [amb_pkg::CntW-1:0]  cfg_wdata_i,
  input  logic [1:0]                req_op_i,
  input  logic [amb_pkg::VtxW-1:0]  req_a_i,
  input  logic [amb_pkg::VtxW-1:0]  req_b_i,
  input  amb_pkg::cmd_t             cmd_i,
  output amb_pkg::stat_t            stat_o,
  amb_res_if.source                 res
);
  import amb_pkg::*;

  logic [CntW-1:0]        vcount_q;
  logic [CntW-1:0]        n;
  logic [1:0]             op_q;
  logic [VtxW-1:0]        a_q, b_q;
  logic                   bfs;

  logic [MaxVertices-1:0] adj_mem [MaxVertices];
  logic [MaxVertices-1:0] rowv_q;
  logic [MaxVertices-1:0] adj_rd_q;
  logic                   rd_vld_q;
  logic [MaxVertices-1:0] row_cur;
  logic [MaxVertices-1:0] row_q;
  logic [VtxW-1:0]        rd_addr, wr_addr, wr_bit;
  logic                   adj_rd, adj_wr;

  logic [VtxW-1:0]        queue_mem [MaxVertices];
  logic [VtxW-1:0]        q_rd_q;
  logic [CntW-1:0]        head_q, tail_q;
  logic [VtxW-1:0]        stack_mem [StackDepth];
  logic [VtxW-1:0]        s_rd_q;
  logic [SpW-1:0]         sp_q, sp_dec;

  logic [MaxVertices-1:0] marks_q;
  logic [VtxW-1:0]        popped, idx_q;
  logic [VtxW-1:0]        pend_q;
  logic                   pend_vld_q;
  logic                   hit, q_push, s_push;

  logic                   out_vld_q;
  logic [VtxW-1:0]        out_v_q;
  logic [1:0]             out_st_q;
  logic                   out_last_q;

  assign n       = (vcount_q > CntW'(MaxVertices)) ? CntW'(MaxVertices) : vcount_q;
  assign bfs     = (op_q == OP_BFS);
  assign popped  = bfs ? q_rd_q : s_rd_q;
  assign row_cur = rd_vld_q ? adj_rd_q : '0;
  assign sp_dec  = sp_q - SpW'(1);

  assign adj_rd  = cmd_i.adj_rd_a | cmd_i.adj_rd_b | cmd_i.fetch;
  assign rd_addr = cmd_i.adj_rd_b ? b_q : (cmd_i.adj_rd_a ? a_q : popped);
  assign adj_wr  = cmd_i.adj_wr_a | cmd_i.adj_wr_b;
  assign wr_addr = cmd_i.adj_wr_b ? b_q : a_q;
  assign wr_bit  = cmd_i.adj_wr_b ? a_q : b_q;

  assign hit     = row_q[idx_q] & ~marks_q[idx_q];
  assign q_push  = cmd_i.scan & bfs & hit & (tail_q < CntW'(MaxVertices));
  assign s_push  = cmd_i.scan & ~bfs & hit & (sp_q < SpW'(StackDepth));

  always_comb begin
    stat_o.op       = op_q;
    stat_o.a_ok     = ({1'b0, a_q} < n);
    stat_o.b_ok     = ({1'b0, b_q} < n);
    stat_o.out_busy = out_vld_q;
    stat_o.scan_end = bfs ? ({1'b0, idx_q} == n - CntW'(1)) : (idx_q == '0);
    stat_o.empty    = bfs ? (head_q == tail_q) : (sp_q == '0);
  end

  // Memories: registered reads
  always_ff @(posedge clk_i) begin
    if (adj_rd) begin
      adj_rd_q <= adj_mem[rd_addr];
    end
    if (adj_wr) begin
      adj_mem[wr_addr] <= row_cur | (MaxVertices'(1) << wr_bit);
    end
    if (cmd_i.pop) begin
      q_rd_q <= queue_mem[head_q[VtxW-1:0]];
      s_rd_q <= stack_mem[sp_dec[StkAw-1:0]];
    end
    if (cmd_i.init) begin
      queue_mem[0] <= a_q;
      stack_mem[0] <= a_q;
    end
    if (q_push) begin
      queue_mem[tail_q[VtxW-1:0]] <= idx_q;
    end
    if (s_push) begin
      stack_mem[sp_q[StkAw-1:0]] <= idx_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= req_op_i;
      a_q  <= req_a_i;
      b_q  <= req_b_i;
    end
    if (cmd_i.load_row) begin
      row_q <= row_cur;
      idx_q <= bfs ? '0 : VtxW'(n - CntW'(1));
    end else if (cmd_i.scan) begin
      idx_q <= bfs ? idx_q + VtxW'(1) : idx_q - VtxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= '0;
      rowv_q     <= '0;
      rd_vld_q   <= 1'b0;
      marks_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      sp_q       <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_v_q    <= '0;
      out_st_q   <= ST_OK;
      out_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      if (adj_rd) begin
        rd_vld_q <= rowv_q[rd_addr];
      end
      if (adj_wr) begin
        rowv_q[wr_addr] <= 1'b1;
      end
      if (res.valid && res.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.init) begin
        marks_q    <= bfs ? (MaxVertices'(1) << a_q) : '0;
        head_q     <= '0;
        tail_q     <= CntW'(1);
        sp_q       <= SpW'(1);
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.pop) begin
        if (bfs) begin
          head_q <= head_q + CntW'(1);
        end else begin
          sp_q <= sp_dec;
        end
      end
      // Emit: every BFS pop, or a DFS pop of an unvisited vertex
      if (cmd_i.fetch && (bfs || !marks_q[popped])) begin
        marks_q[popped] <= 1'b1;
        if (pend_vld_q) begin
          out_vld_q  <= 1'b1;
          out_v_q    <= pend_q;
          out_st_q   <= ST_OK;
          out_last_q <= 1'b0;
        end
        pend_q     <= popped;
        pend_vld_q <= 1'b1;
      end
      if (q_push) begin
        tail_q         <= tail_q + CntW'(1);
        marks_q[idx_q] <= 1'b1;
      end
      if (s_push) begin
        sp_q <= sp_q + SpW'(1);
      end
      if (cmd_i.finish) begin
        out_vld_q  <= 1'b1;
        out_v_q    <= pend_q;
        out_st_q   <= ST_OK;
        out_last_q <= 1'b1;
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.reply) begin
        out_vld_q  <= 1'b1;
        out_v_q    <= '0;
        out_st_q   <= cmd_i.reply_status;
        out_last_q <= 1'b1;
      end
    end
  end

  assign res.valid          = out_vld_q;
  assign res.visited_vertex = out_v_q;
  assign res.status         = out_st_q;
  assign res.last           = out_last_q;

endmodule

/* design/amb_ctrl.sv */
// Controller state machine sequencing edge adds and traversals.
module amb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  amb_pkg::stat_t  stat_i,
  output amb_pkg::cmd_t   cmd_o
);
  import amb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ADD_RDA, S_ADD_WRA, S_ADD_RDB, S_ADD_WRB, S_REPLY,
    S_INIT, S_POP, S_FETCH, S_ROW, S_SCAN, S_CHECK, S_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] code_q, code_d;

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    cmd_o.reply_status = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (stat_i.op == OP_ADD) begin
          if (stat_i.a_ok && stat_i.b_ok) begin
            state_d = S_ADD_RDA;
          end else begin
            code_d  = ST_EDGE_RANGE;
            state_d = S_REPLY;
          end
        end else if (stat_i.op == OP_BFS || stat_i.op == OP_DFS) begin
          if (stat_i.a_ok) begin
            state_d = S_INIT;
          end else begin
            code_d  = ST_START_RANGE;
            state_d = S_REPLY;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ADD_RDA: begin
        cmd_o.adj_rd_a = 1'b1;
        state_d        = S_ADD_WRA;
      end
      S_ADD_WRA: begin
        cmd_o.adj_wr_a = 1'b1;
        state_d        = S_ADD_RDB;
      end
      S_ADD_RDB: begin
        cmd_o.adj_rd_b = 1'b1;
        state_d        = S_ADD_WRB;
      end
      S_ADD_WRB: begin
        cmd_o.adj_wr_b = 1'b1;
        code_d         = ST_OK;
        state_d        = S_REPLY;
      end
      S_REPLY: begin
        if (!stat_i.out_busy) begin
          cmd_o.reply = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_POP;
      end
      S_POP: begin
        if (!stat_i.out_busy) begin
          cmd_o.pop = 1'b1;
          state_d   = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_ROW;
      end
      S_ROW: begin
        cmd_o.load_row = 1'b1;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_end) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = stat_i.empty ? S_FINISH : S_POP;
      end
      S_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);

endmodule

/* design/adjacency_matrix_bfs_dfs.sv */
// A traversal scans n bits of each popped vertex's adjacency row, one bit a cycle (n = live
// vertex count, capped at MaxVertices); DFS may pop up to about n*n entries.
// One request is worked at a time; a result waiting in the output register holds the next pop.
// Reset clears the adjacency valid bits, marks, pointers and vertex count at once; the
// queue and stack memories are not cleared and need no clearing pass.
module adjacency_matrix_bfs_dfs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [amb_pkg::CntW-1:0]  cfg_wdata_i,
  amb_req_if.sink                   in_i,
  amb_res_if.source                 out_o
);
  import amb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller: accepts a request, then steps the datapath through it
  amb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: holds the graph, search state and the result register
  amb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_op_i    (in_i.operation),
    .req_a_i     (in_i.vertex_a),
    .req_b_i     (in_i.vertex_b),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res         (out_o)
  );

endmodule
